// ===== hw/rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

  // Table geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int RANK_W     = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int OP_W       = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Stream word sizes, padded to whole bytes
  localparam int IN_BITS  = OP_W + KEY_BITS + VALUE_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + VALUE_BITS + 1 + KEY_BITS + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  capture;      // register match and victim flags
    logic [KEY_BITS-1:0]   cmp_key;
    logic [RANK_W-1:0]     last_rank;    // rank of the least recent entry
    logic                  promote;      // make the matched entry most recent
    logic                  write_value;  // overwrite the matched entry's value
    logic                  remove;       // drop the matched entry
    logic                  insert_new;   // place a new entry in the first free cell
    logic                  evict;        // drop the least recent entry first
    logic [RANK_W-1:0]     hit_rank;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] new_value;
  } cell_ctrl_t;

  // Lookup results gathered along the row
  typedef struct packed {
    logic                  hit;
    logic [RANK_W-1:0]     rank;
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   ev_key;
  } look_chain_t;

endpackage

// ===== hw/rtl/lkv_cell.sv =====
`timescale 1ns / 1ps

module lkv_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkv_pkg::cell_ctrl_t  ctrl,
  input  lkv_pkg::look_chain_t look_in,
  output lkv_pkg::look_chain_t look_out,
  input  logic                 claim_in,   // a lower cell is already free
  output logic                 claim_out
);

  logic                           valid_r, valid_nxt;
  logic [lkv_pkg::RANK_W-1:0]     rank_r, rank_nxt;
  logic [lkv_pkg::KEY_BITS-1:0]   key_r, key_nxt;
  logic [lkv_pkg::VALUE_BITS-1:0] value_r, value_nxt;
  logic                           match_r, victim_r;

  logic match_c, victim_c, drop, live, claim;

  // Compare against the incoming key and the least recent rank
  assign match_c  = valid_r && (key_r == ctrl.cmp_key);
  assign victim_c = valid_r && (rank_r == ctrl.last_rank);

  // Merge this cell's findings into the row
  assign look_out.hit    = look_in.hit | match_c;
  assign look_out.rank   = look_in.rank | (match_c ? rank_r : '0);
  assign look_out.value  = look_in.value | (match_c ? value_r : '0);
  assign look_out.ev_key = look_in.ev_key | (victim_c ? key_r : '0);

  // Free-slot chain: lowest free cell after eviction takes the new entry
  assign drop      = ctrl.evict && victim_r;
  assign live      = valid_r && !drop;
  assign claim_out = claim_in | !live;
  assign claim     = ctrl.insert_new && !live && !claim_in;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.promote) begin
      if (match_r) begin
        rank_nxt = '0;
        if (ctrl.write_value) begin
          value_nxt = ctrl.new_value;
        end
      end else if (valid_r && (rank_r < ctrl.hit_rank)) begin
        rank_nxt = rank_r + lkv_pkg::RANK_W'(1);
      end
    end else if (ctrl.remove) begin
      if (match_r) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end else if (valid_r && (rank_r > ctrl.hit_rank)) begin
        rank_nxt = rank_r - lkv_pkg::RANK_W'(1);
      end
    end else if (ctrl.insert_new) begin
      if (claim) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        key_nxt   = ctrl.new_key;
        value_nxt = ctrl.new_value;
      end else if (live) begin
        rank_nxt = rank_r + lkv_pkg::RANK_W'(1);
      end else if (drop) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rank_r   <= '0;
      match_r  <= 1'b0;
      victim_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      if (ctrl.capture) begin
        match_r  <= match_c;
        victim_r <= victim_c;
      end
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps

// One word at a time: an accepted word is held in APPLY and in_tready stays
// low until it leaves. The cell row compares in the accept cycle; ranks,
// entries and the result word are updated as the word leaves APPLY, which
// waits while a result is pending and out_tready is low.
// Reset (rst_n low, synchronous): table empty, all ranks zero, occupancy zero,
// capacity 16, no result pending.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: operation[1:0], key[33:2], value[65:34], zero pad above
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lkv_pkg::IN_W-1:0]   in_tdata,
  // out_tdata: hit[0], read_value[32:1], evicted[33], evicted_key[65:34],
  //            occupancy[70:66], zero pad above
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lkv_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data
);

  localparam int KB = lkv_pkg::KEY_BITS;
  localparam int VB = lkv_pkg::VALUE_BITS;
  localparam int OW = lkv_pkg::OP_W;
  localparam int NE = lkv_pkg::ENTRIES;

  lkv_pkg::state_t state_r, state_nxt;

  logic [OW-1:0]              op_r;
  logic [KB-1:0]              key_r;
  logic [VB-1:0]              val_r;
  logic                       hit_r;
  logic [lkv_pkg::RANK_W-1:0] hrank_r;
  logic [VB-1:0]              rd_r;
  logic [KB-1:0]              evk_r;
  logic [lkv_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [lkv_pkg::CAP_W-1:0]  capacity_r;

  logic                       out_valid_r;
  logic [lkv_pkg::OUT_W-1:0]  out_data_r;

  logic                       in_fire, advance;
  logic [OW-1:0]              in_op;
  logic [KB-1:0]              in_key;
  logic [VB-1:0]              in_value;
  logic [lkv_pkg::CNT_W-1:0]  cnt_m1;
  logic [lkv_pkg::CMP_W-1:0]  eff_cap, cap_ext, cnt_ext;
  logic                       is_lookup, is_insert, is_delete, full;
  logic                       ev, ins_new;
  lkv_pkg::cell_ctrl_t        ctrl;
  lkv_pkg::look_chain_t       look [NE+1];
  logic                       claim [NE+1];

  // Unpack the input word
  assign in_op    = in_tdata[OW-1:0];
  assign in_key   = in_tdata[OW+KB-1:OW];
  assign in_value = in_tdata[OW+KB+VB-1:OW+KB];

  assign in_tready = (state_r == lkv_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = (state_r == lkv_pkg::ST_APPLY) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // Clamp capacity to 1..ENTRIES and test for a full table
  assign cap_ext = lkv_pkg::CMP_W'(capacity_r);
  assign cnt_ext = lkv_pkg::CMP_W'(count_r);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = lkv_pkg::CMP_W'(1);
    end else if (cap_ext > lkv_pkg::CMP_W'(NE)) begin
      eff_cap = lkv_pkg::CMP_W'(NE);
    end
  end
  assign full = (cnt_ext >= eff_cap);

  assign cnt_m1    = count_r - lkv_pkg::CNT_W'(1);
  assign is_lookup = (op_r == lkv_pkg::OP_LOOKUP);
  assign is_insert = (op_r == lkv_pkg::OP_INSERT);
  assign is_delete = (op_r == lkv_pkg::OP_DELETE);
  assign ins_new   = is_insert && !hit_r;
  assign ev        = ins_new && full;

  // Drive the cell row
  always_comb begin
    ctrl             = '0;
    ctrl.capture     = in_fire;
    ctrl.cmp_key     = in_key;
    ctrl.last_rank   = cnt_m1[lkv_pkg::RANK_W-1:0];
    ctrl.hit_rank    = hrank_r;
    ctrl.new_key     = key_r;
    ctrl.new_value   = val_r;
    ctrl.promote     = advance && hit_r && (is_lookup || is_insert);
    ctrl.write_value = is_insert;
    ctrl.remove      = advance && hit_r && is_delete;
    ctrl.insert_new  = advance && ins_new;
    ctrl.evict       = ev;
  end

  assign look[0]  = '0;
  assign claim[0] = 1'b0;

  for (genvar g = 0; g < NE; g++) begin : g_cell
    lkv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .look_in   (look[g]),
      .look_out  (look[g+1]),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1])
    );
  end

  // Occupancy after the update
  always_comb begin
    count_nxt = count_r;
    if (advance) begin
      if (ins_new && !ev) begin
        count_nxt = count_r + lkv_pkg::CNT_W'(1);
      end else if (is_delete && hit_r) begin
        count_nxt = count_r - lkv_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkv_pkg::ST_IDLE:  if (in_fire) state_nxt = lkv_pkg::ST_APPLY;
      lkv_pkg::ST_APPLY: if (advance) state_nxt = lkv_pkg::ST_IDLE;
      default:           state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      count_r     <= '0;
      capacity_r  <= lkv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item and the row's lookup results for the update cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_op;
      key_r   <= in_key;
      val_r   <= in_value;
      hit_r   <= look[NE].hit;
      hrank_r <= look[NE].rank;
      rd_r    <= look[NE].value;
      evk_r   <= look[NE].ev_key;
    end
  end

  // Build the result word
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= lkv_pkg::OUT_W'({count_nxt,
                                     (ev ? evk_r : {KB{1'b0}}),
                                     ev,
                                     ((is_lookup && hit_r) ? rd_r : {VB{1'b0}}),
                                     (hit_r && (is_lookup || is_insert || is_delete))});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam logic [lkv_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [lkv_pkg::OP_W-1:0]       op;
    logic [lkv_pkg::KEY_BITS-1:0]   key;
    logic [lkv_pkg::VALUE_BITS-1:0] value;
  } cache_op_t;

  typedef struct {
    logic                           hit;
    logic [lkv_pkg::VALUE_BITS-1:0] read_value;
    logic                           evicted;
    logic [lkv_pkg::KEY_BITS-1:0]   evicted_key;
    logic [lkv_pkg::CNT_W-1:0]      occupancy;
  } cache_reply_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [lkv_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [lkv_pkg::OUT_W-1:0] out_tdata;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [lkv_pkg::CAP_W-1:0] cfg_data   = '0;

  // Words waiting to be sent and replies the cache owes us
  cache_op_t    queued_ops[$];
  cache_reply_t predicted_replies[$];

  // Mirror of the table
  logic                           slot_valid [lkv_pkg::ENTRIES];
  logic [lkv_pkg::KEY_BITS-1:0]   slot_key   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VALUE_BITS-1:0] slot_value [lkv_pkg::ENTRIES];
  int                             slot_rank  [lkv_pkg::ENTRIES];
  int                             live_count;
  logic [lkv_pkg::CAP_W-1:0]      capacity_reg;

  int failures       = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit in_taken       = 1'b0;
  bit hold_armed     = 1'b0;
  int hold_count     = 0;
  int quiet_cycles   = 0;

  lru_key_value_cache DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move slot s to the front of the recency order
  function automatic void promote_slot(int s);
    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
      if (slot_valid[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  // Invalidate slot s and close the rank gap behind it
  function automatic void drop_slot(int s);
    int old_rank;
    old_rank = slot_rank[s];
    slot_valid[s] = 1'b0;
    slot_rank[s] = 0;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
      if (slot_valid[i] && slot_rank[i] > old_rank) slot_rank[i]--;
    if (live_count > 0) live_count--;
  endfunction

  function automatic cache_reply_t lru_apply(cache_op_t c);
    cache_reply_t r;
    int found;
    int victim;
    int free_slot;
    int cap_eff;
    r.hit = 1'b0;
    r.read_value = '0;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    found = -1;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == c.key) found = i;
    case (c.op)
      lkv_pkg::OP_LOOKUP: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.read_value = slot_value[found];
          promote_slot(found);
        end
      end
      lkv_pkg::OP_INSERT: begin
        if (found >= 0) begin
          // existing key: overwrite and promote, never evict
          r.hit = 1'b1;
          slot_value[found] = c.value;
          promote_slot(found);
        end else begin
          cap_eff = (capacity_reg == 0) ? 1 :
                    (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES :
                    int'(capacity_reg);
          if (live_count >= cap_eff) begin
            victim = -1;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
              if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                victim = i;
            if (victim >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = slot_key[victim];
              drop_slot(victim);
            end
          end
          free_slot = -1;
          for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (free_slot < 0 && !slot_valid[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
              if (slot_valid[i]) slot_rank[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = c.key;
            slot_value[free_slot] = c.value;
            slot_rank[free_slot]  = 0;
            live_count++;
          end
        end
      end
      lkv_pkg::OP_DELETE: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          drop_slot(found);
        end
      end
      default: ;
    endcase
    r.occupancy = live_count[lkv_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  // Predict on each accepted word, compare each delivered word
  always @(posedge clk) begin
    cache_op_t    op_in;
    cache_reply_t want;
    cache_reply_t got;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        op_in.op    = in_tdata[1:0];
        op_in.key   = in_tdata[33:2];
        op_in.value = in_tdata[65:34];
        predicted_replies.push_back(lru_apply(op_in));
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.hit         = out_tdata[0];
        got.read_value  = out_tdata[32:1];
        got.evicted     = out_tdata[33];
        got.evicted_key = out_tdata[65:34];
        got.occupancy   = out_tdata[70:66];
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_tdata);
          failures++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("read_value", want.read_value, got.read_value);
          check_field("evicted", 32'(want.evicted), 32'(got.evicted));
          check_field("evicted_key", want.evicted_key, got.evicted_key);
          check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        end
      end
    end
  end

  // Offer the next word once the current one is taken, idling at random
  always @(negedge clk) begin
    cache_op_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_ops.pop_front();
        in_tdata  <= lkv_pkg::IN_W'({nxt.value, nxt.key, nxt.op});
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random; hold off once for a long stretch
  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count++;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort if no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic [lkv_pkg::OP_W-1:0] op,
                          input logic [lkv_pkg::KEY_BITS-1:0] key,
                          input logic [lkv_pkg::VALUE_BITS-1:0] value);
    cache_op_t c;
    c.op = op;
    c.key = key;
    c.value = value;
    queued_ops.push_back(c);
  endtask

  task automatic wait_drained();
    while (queued_ops.size() != 0 || in_tvalid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain, set capacity, idling and stalling, then queue random words over a key pool
  task automatic run_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input int idle_pct,
                           input int stall_pct, input int n, input int pool_n);
    logic [lkv_pkg::KEY_BITS-1:0] pool[$];
    int roll;
    logic [lkv_pkg::OP_W-1:0] op;
    logic [lkv_pkg::KEY_BITS-1:0] key;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < pool_n; i++) pool.push_back($urandom());
    repeat (n) begin
      roll = $urandom_range(99);
      op = (roll < 36) ? lkv_pkg::OP_LOOKUP : (roll < 70) ? lkv_pkg::OP_INSERT :
           (roll < 96) ? lkv_pkg::OP_DELETE : OP_UNUSED;
      // mostly pool keys so hits and evictions are frequent
      key = ($urandom_range(99) < 88) ? pool[$urandom_range(pool_n - 1)] : $urandom();
      queue_op(op, key, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_rank[i]  = 0;
    end
    live_count   = 0;
    capacity_reg = lkv_pkg::CAP_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, key and value extremes, unused code, update, fill and evict
    queue_op(lkv_pkg::OP_LOOKUP, 32'h0, 32'h0);
    queue_op(lkv_pkg::OP_DELETE, 32'h0, 32'h0);
    queue_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(lkv_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    queue_op(lkv_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    queue_op(lkv_pkg::OP_LOOKUP, 32'h0, 32'h0);
    queue_op(lkv_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(lkv_pkg::OP_INSERT, 32'h0, 32'h5A5A_5A5A);
    queue_op(OP_UNUSED, 32'h0, 32'h0);
    queue_op(lkv_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0);
    queue_op(lkv_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0);
    for (int i = 1; i <= lkv_pkg::ENTRIES; i++)
      queue_op(lkv_pkg::OP_INSERT, 32'h1000 + i, ~i);
    queue_op(lkv_pkg::OP_LOOKUP, 32'h1001, 32'h0);
    queue_op(lkv_pkg::OP_INSERT, 32'hDEAD_BEEF, 32'h1234_5678);

    run_phase(5'd31, 0, 0, 250, 24);
    run_phase(5'd1, 77, 0, 200, 6);
    run_phase(5'd0, 0, 77, 150, 4);
    run_phase(5'd16, 24, 24, 300, 20);
    // fill the table, then shrink capacity below occupancy
    repeat (lkv_pkg::ENTRIES) queue_op(lkv_pkg::OP_INSERT, $urandom(), $urandom());
    run_phase(5'd3, 24, 24, 250, 8);
    run_phase(5'd8, 0, 0, 250, 12);
    hold_armed = 1'b1;
    run_phase(5'd17, 77, 24, 200, 10);
    run_phase(5'd2, 24, 77, 100, 5);
    run_phase(5'd5, 24, 24, 200, 16);
    wait_drained();

    if (failures == 0 && predicted_replies.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
